// ===== hdl/assert_macros.svh =====
// Assertion macros for the nearest node steer RTL.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define NNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define NNS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define NNS_ASSERT(lbl, prop, msg)
`define NNS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/nns_pkg.sv =====
// Package for the nearest node steer block: sizes, codes, steering request.
// No dependencies.
package nns_pkg;
  localparam int MAX_NODES  = 4096;
  localparam int COORD_BITS = 10;
  localparam int IDX_BITS   = $clog2(MAX_NODES);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int DSQ_BITS   = 2 * COORD_BITS + 1;
  localparam int STEP_BITS  = 6;
  localparam int MIND_BITS  = 11;
  localparam int OUT_BITS   = 12;
  localparam int FRAC_BITS  = 16;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic REG_STEP_LENGTH = 1'b0;
  localparam logic REG_MIN_DIST    = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS-1:0]      near_x;
    logic [COORD_BITS-1:0]      near_y;
    logic [DSQ_BITS-1:0]        dsq;
    logic [STEP_BITS-1:0]       step;
  } steer_req_t;
endpackage

// ===== hdl/nns_node_mem.sv =====
// Node point table: one write port, one read port, registered read data.
// Depends on nns_pkg.
module nns_node_mem import nns_pkg::*; (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IDX_BITS-1:0]     waddr_i,
  input  logic [2*COORD_BITS-1:0] wdata_i,   // x low, y high
  input  logic                    re_i,
  input  logic [IDX_BITS-1:0]     raddr_i,
  output logic [2*COORD_BITS-1:0] rdata_o
);
  logic [2*COORD_BITS-1:0] mem_q [MAX_NODES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ===== hdl/nns_steer.sv =====
// Steering unit: per axis a restoring divide, a digit-by-digit square root,
// a multiply by step length and a truncating add. Depends on nns_pkg.
module nns_steer import nns_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  steer_req_t                 req_i,
  output logic                       done_o,
  output logic signed [OUT_BITS-1:0] step_x_o,
  output logic signed [OUT_BITS-1:0] step_y_o
);
  localparam int Q_W   = 2 * FRAC_BITS + 1;
  localparam int RT_W  = 2 * FRAC_BITS + 2;
  localparam int F_W   = FRAC_BITS + 1;
  localparam int OFF_W = STEP_BITS + F_W;
  localparam int P_W   = COORD_BITS + FRAC_BITS + 2;
  localparam int IT_W  = $clog2(2 * FRAC_BITS);
  localparam logic [IT_W-1:0] DIV_LAST  = IT_W'(2 * FRAC_BITS - 1);
  localparam logic [IT_W-1:0] ROOT_LAST = IT_W'(FRAC_BITS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_DIV0 = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_ADD  = 3'd6;

  logic [2:0]                 state_q;
  logic                       axis_q, done_q;
  logic [IT_W-1:0]            iter_q;
  steer_req_t                 req_q;
  logic [2*COORD_BITS-1:0]    num_q;
  logic [DSQ_BITS-1:0]        r_q;
  logic [Q_W-1:0]             q_q;
  logic [RT_W-1:0]            v_q, res_q, bit_q;
  logic [OFF_W-1:0]           off_q;
  logic signed [OUT_BITS-1:0] sx_q, sy_q;

  logic signed [COORD_BITS:0] cur_d;
  logic [COORD_BITS:0]        mag_w;
  logic [COORD_BITS-1:0]      cur_near;
  logic [DSQ_BITS:0]          r_sh;
  logic                       r_ge, n_ge;
  logic [RT_W-1:0]            trial;
  logic                       v_ge;
  logic signed [P_W-1:0]      base, offs, p_sum, p_neg;
  logic signed [P_W-1:0]      p_trunc;

  assign cur_d    = axis_q ? req_q.dy : req_q.dx;
  assign cur_near = axis_q ? req_q.near_y : req_q.near_x;
  assign mag_w    = cur_d[COORD_BITS] ? (COORD_BITS+1)'(-cur_d) : cur_d;
  assign n_ge     = {1'b0, num_q} >= req_q.dsq;
  assign r_sh     = {r_q, 1'b0};
  assign r_ge     = r_sh >= {1'b0, req_q.dsq};
  assign trial    = res_q + bit_q;
  assign v_ge     = v_q >= trial;
  assign base     = $signed({2'b00, cur_near, {FRAC_BITS{1'b0}}});
  assign offs     = $signed(P_W'(off_q));
  assign p_sum    = cur_d[COORD_BITS] ? base - offs : base + offs;
  assign p_neg    = -p_sum;
  // truncate toward zero, the whole sum
  assign p_trunc  = p_sum[P_W-1] ? -(p_neg >>> FRAC_BITS) : (p_sum >>> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 1'b0;
      done_q  <= 1'b0;
      iter_q  <= '0;
    end else begin
      // done: zero distance right after start, or after the second axis
      done_q <= ((state_q == ST_IDLE) && start_i && (req_i.dsq == '0)) ||
                ((state_q == ST_ADD) && axis_q);
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            axis_q <= 1'b0;
            if (req_i.dsq != '0) begin
              state_q <= ST_SQR;
            end
          end
        end
        ST_SQR:  state_q <= ST_DIV0;
        ST_DIV0: begin
          state_q <= ST_DIV;
          iter_q  <= '0;
        end
        ST_DIV: begin
          if (iter_q == DIV_LAST) begin
            state_q <= ST_ROOT;
            iter_q  <= '0;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        ST_ROOT: begin
          iter_q <= iter_q + 1'b1;
          if (iter_q == ROOT_LAST) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL:  state_q <= ST_ADD;
        ST_ADD: begin
          if (axis_q) begin
            state_q <= ST_IDLE;
          end else begin
            axis_q  <= 1'b1;
            state_q <= ST_SQR;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_q <= req_i;
          sx_q  <= $signed(OUT_BITS'(req_i.near_x));
          sy_q  <= $signed(OUT_BITS'(req_i.near_y));
        end
      end
      ST_SQR:  num_q <= (2*COORD_BITS)'(mag_w[COORD_BITS-1:0] * mag_w[COORD_BITS-1:0]);
      ST_DIV0: begin
        r_q <= n_ge ? DSQ_BITS'({1'b0, num_q} - req_q.dsq) : DSQ_BITS'(num_q);
        q_q <= Q_W'(n_ge);
      end
      ST_DIV: begin
        r_q <= r_ge ? DSQ_BITS'(r_sh - {1'b0, req_q.dsq}) : DSQ_BITS'(r_sh);
        q_q <= {q_q[Q_W-2:0], r_ge};
        if (iter_q == DIV_LAST) begin
          v_q   <= {1'b0, q_q[Q_W-2:0], r_ge};
          res_q <= '0;
          bit_q <= RT_W'(1) << (2 * FRAC_BITS);
        end
      end
      ST_ROOT: begin
        if (v_ge) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_MUL:  off_q <= OFF_W'(req_q.step * res_q[F_W-1:0]);
      ST_ADD: begin
        if (axis_q) begin
          sy_q <= p_trunc[OUT_BITS-1:0];
        end else begin
          sx_q <= p_trunc[OUT_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign step_x_o = sx_q;
  assign step_y_o = sy_q;
endmodule

// ===== hdl/nearest_node_steer_core.sv =====
// An insert writes the point to the node table at the next free slot unless the table
// is full; the result word with its slot index is registered when the word is accepted.
// A query scans the N stored nodes, one table read per cycle through the single read
// port of the node memory, through the read and square pipeline registers and a closing
// step, then runs the steering unit (per axis one square, 33 divide steps, 17 square
// root steps, a multiply and an add, then a step to flag done), then loads the result
// register. A query at zero distance skips the steering steps and flags done directly.
// The block takes a new word only when idle and its result register is free or being
// drained. The table has no clearing pass; entries are read only below the fill count.
`include "assert_macros.svh"
module nearest_node_steer_core import nns_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration write port
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [10:0]   cfg_data_i,
  // input words
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [23:0]   s_axis_tdata,   // point_x, point_y, zero pad
  input  logic          s_axis_tuser,   // op
  // result words
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [79:0]   m_axis_tdata,   // node_index, near_x, near_y, dist_sq,
                                        // too_close, step_x, step_y, zero pad
  output logic [1:0]    m_axis_tuser    // status
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_STEER = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(MAX_NODES);

  logic [1:0]            state_q;
  logic [STEP_BITS-1:0]  step_q;
  logic [MIND_BITS-1:0]  mind_q;
  logic [CNT_BITS-1:0]   cnt_q, iss_q;
  logic [COORD_BITS-1:0] qx_q, qy_q;

  // scan pipeline
  logic                  v1_q, v2_q;
  logic [IDX_BITS-1:0]   idx1_q, idx2_q;
  logic [COORD_BITS-1:0] nx2_q, ny2_q;
  logic [2*COORD_BITS-1:0] sqx_q, sqy_q;
  logic                  best_vld_q;
  logic [DSQ_BITS-1:0]   best_d_q;
  logic [IDX_BITS-1:0]   best_idx_q;
  logic [COORD_BITS-1:0] best_x_q, best_y_q;
  logic [2*MIND_BITS-1:0] mdsq_q;

  // result register
  logic                  o_vld_q;
  logic [1:0]            o_status_q;
  logic [IDX_BITS-1:0]   o_idx_q;
  logic [COORD_BITS-1:0] o_nx_q, o_ny_q;
  logic [DSQ_BITS-1:0]   o_dsq_q;
  logic                  o_tc_q;
  logic [OUT_BITS-1:0]   o_sx_q, o_sy_q;

  logic [COORD_BITS-1:0] in_x, in_y, rd_x, rd_y;
  logic [2*COORD_BITS-1:0] rd_data;
  logic                  in_acc, out_free, full, rd_en, scan_end, fin_load;
  logic signed [COORD_BITS:0] ex, ey;
  logic [DSQ_BITS-1:0]   d_sum;
  logic                  d_better;
  steer_req_t            sreq;
  logic                  s_start, s_done;
  logic signed [OUT_BITS-1:0] s_x, s_y;

  assign in_x     = s_axis_tdata[COORD_BITS-1:0];
  assign in_y     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign out_free = !o_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign full     = cnt_q == FULL_CNT;
  assign rd_en    = (state_q == S_SCAN) && (iss_q != cnt_q);
  assign scan_end = (state_q == S_SCAN) && (iss_q == cnt_q) && !v1_q && !v2_q;
  assign fin_load = (state_q == S_FIN) && out_free;
  assign s_start  = scan_end;

  // writes happen only while idle and reads only while scanning: no overlap
  nns_node_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (in_acc && (s_axis_tuser == OP_INSERT) && !full),
    .waddr_i (cnt_q[IDX_BITS-1:0]),
    .wdata_i ({in_y, in_x}),
    .re_i    (rd_en),
    .raddr_i (iss_q[IDX_BITS-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_x = rd_data[COORD_BITS-1:0];
  assign rd_y = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign ex   = $signed({1'b0, qx_q}) - $signed({1'b0, rd_x});
  assign ey   = $signed({1'b0, qy_q}) - $signed({1'b0, rd_y});
  assign d_sum    = DSQ_BITS'(sqx_q) + DSQ_BITS'(sqy_q);
  assign d_better = !best_vld_q || (d_sum < best_d_q);   // strict: earliest wins a tie

  assign sreq.dx     = $signed({1'b0, qx_q}) - $signed({1'b0, best_x_q});
  assign sreq.dy     = $signed({1'b0, qy_q}) - $signed({1'b0, best_y_q});
  assign sreq.near_x = best_x_q;
  assign sreq.near_y = best_y_q;
  assign sreq.dsq    = best_d_q;
  assign sreq.step   = step_q;

  nns_steer u_steer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (s_start),
    .req_i    (sreq),
    .done_o   (s_done),
    .step_x_o (s_x),
    .step_y_o (s_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= STEP_BITS'(20);
      mind_q     <= MIND_BITS'(10);
      cnt_q      <= '0;
      iss_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      best_vld_q <= 1'b0;
      o_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_STEP_LENGTH: step_q <= cfg_data_i[STEP_BITS-1:0];
          REG_MIN_DIST:    mind_q <= cfg_data_i[MIND_BITS-1:0];
          default: ;
        endcase
      end
      // a query on a non-empty table holds its word back until the steering result is loaded
      if (in_acc) begin
        o_vld_q <= !((s_axis_tuser == OP_QUERY) && (cnt_q != '0));
      end else if (fin_load) begin
        o_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_vld_q <= 1'b0;
      end
      v1_q <= rd_en;
      v2_q <= v1_q;
      if (v2_q && d_better) begin
        best_vld_q <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == OP_INSERT) begin
              if (!full) begin
                cnt_q <= cnt_q + 1'b1;
              end
            end else if (cnt_q != '0) begin
              state_q    <= S_SCAN;
              iss_q      <= '0;
              best_vld_q <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            iss_q <= iss_q + 1'b1;
          end
          if (scan_end) begin
            state_q <= S_STEER;
          end
        end
        S_STEER: begin
          if (s_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (state_q == S_IDLE)) begin
      qx_q <= in_x;
      qy_q <= in_y;
    end
    idx1_q <= iss_q[IDX_BITS-1:0];
    idx2_q <= idx1_q;
    nx2_q  <= rd_x;
    ny2_q  <= rd_y;
    sqx_q  <= (2*COORD_BITS)'(ex * ex);
    sqy_q  <= (2*COORD_BITS)'(ey * ey);
    if (v2_q && d_better) begin
      best_d_q   <= d_sum;
      best_idx_q <= idx2_q;
      best_x_q   <= nx2_q;
      best_y_q   <= ny2_q;
    end
    if (scan_end) begin
      mdsq_q <= (2*MIND_BITS)'(mind_q * mind_q);
    end
    if (in_acc) begin
      o_nx_q  <= '0;
      o_ny_q  <= '0;
      o_dsq_q <= '0;
      o_tc_q  <= 1'b0;
      o_sx_q  <= '0;
      o_sy_q  <= '0;
      if (s_axis_tuser == OP_INSERT) begin
        o_status_q <= full ? STATUS_FULL : STATUS_OK;
        o_idx_q    <= full ? '0 : cnt_q[IDX_BITS-1:0];
      end else begin
        o_status_q <= STATUS_EMPTY;
        o_idx_q    <= '0;
      end
    end else if (fin_load) begin
      o_status_q <= STATUS_OK;
      o_idx_q    <= best_idx_q;
      o_nx_q     <= best_x_q;
      o_ny_q     <= best_y_q;
      o_dsq_q    <= best_d_q;
      o_tc_q     <= {1'b0, best_d_q} < mdsq_q;
      o_sx_q     <= s_x;
      o_sy_q     <= s_y;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tdata  = {2'b00, o_sy_q, o_sx_q, o_tc_q, o_dsq_q, o_ny_q, o_nx_q, o_idx_q};

  `NNS_ASSERT(a_rd_only_scan, rd_en |-> (iss_q < cnt_q), "table read at or beyond fill count")
  `NNS_ASSERT(a_cnt_bound, cnt_q <= FULL_CNT, "node count beyond table size")
  `NNS_ASSERT(a_steer_in_steer, s_done |-> (state_q == S_STEER), "steer done outside steer phase")
  `NNS_ASSERT(a_fin_best, (state_q == S_FIN) |-> best_vld_q, "query result without a best node")
endmodule
